// ===== hw/rtl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the sorted list engine
// Opcodes, result status codes, widths and the compare result bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sle_pkg;

  // Default table depth
  localparam int unsigned CAPACITY_DEF = 32;

  // Width of one stored key
  localparam int unsigned KEY_W = 16;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_DELETE    = 2'd1,
    OP_DUMP_ASC  = 2'd2,
    OP_DUMP_DESC = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // Outcome of one signed key compare: key versus stored entry
  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

endpackage

// ===== hw/rtl/sorted_list_engine.sv =====
// ----------------------------------------------------------------------------
// sorted_list_engine: bounded ascending table with insert, delete and dumps
// Sequencer around one table RAM and one shared signed comparator.
// ----------------------------------------------------------------------------
// The table holds up to CAPACITY signed 16-bit keys in ascending order in a
// single RAM with registered read; one comparator serves every compare step.
// Work is one item at a time: s_axis_tready_o is high only while the engine
// is idle. Every table step is a RAM read, then a compare, move or output.
// An insert reads entries from the top down, moves each one that is not
// below the key up one slot, and stops on a smaller one or lands at the
// front; a delete scans for the key and, if it is found, shifts the tail
// down over it; a dump reads every entry in turn and waits out any output
// stall. An insert into a full table, an insert into an empty table, and a
// delete or dump of an empty table go straight to their single result. A
// result waits in the output register while the next beat is accepted; the
// engine only stalls when it must emit again before that result is taken.
// Input beat: tuser = opcode (0 insert, 1 delete, 2 dump ascending,
// 3 dump descending), tdata = key. Output beat: tdata = value, tuser =
// status (0 ok, 1 full and dropped, 2 not found, 3 list empty), tlast marks
// the final result of an item. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_engine #(
  parameter int unsigned CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] key_value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] opcode
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] out_value
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  output logic        m_axis_tlast_o    // last
);

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned KW   = sle_pkg::KEY_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_CMP,
    S_SHF_RD,
    S_SHF_WR,
    S_DMP_RD,
    S_DMP_OUT,
    S_EMIT
  } state_e;

  state_e                state_q;
  logic [KW-1:0]         key_q;
  logic [AW-1:0]         idx_q;
  logic [CW-1:0]         count_q;
  logic                  dump_desc_q;
  logic [KW-1:0]         res_value_q;
  sle_pkg::status_e      res_status_q;
  logic                  m_tvalid_q;
  logic [KW-1:0]         m_tdata_q;
  sle_pkg::status_e      m_tuser_q;
  logic                  m_tlast_q;

  logic                  s_fire;
  logic                  out_free;
  logic                  out_load;
  sle_pkg::op_e          op_in;
  logic                  is_full;
  logic                  is_empty;
  logic [AW-1:0]         last_idx;
  logic [AW-1:0]         dump_addr;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [KW-1:0]         ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [KW-1:0]         ram_rdata;
  sle_pkg::cmp_res_t     cmp_res;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  // the output register can take a new result this cycle
  assign out_free        = !m_tvalid_q || m_axis_tready_i;
  // a result enters the output register this cycle
  assign out_load        = out_free && (state_q == S_EMIT || state_q == S_DMP_OUT);
  assign op_in           = sle_pkg::op_e'(s_axis_tuser_i);

  assign is_full   = (count_q == CW'(CAPACITY));
  assign is_empty  = (count_q == '0);
  assign last_idx  = AW'(count_q - CW'(1));
  // descending dump walks from the top entry down
  assign dump_addr = dump_desc_q ? (last_idx - idx_q) : idx_q;

  // Table storage: one write and one read port
  sle_ram #(
    .WIDTH (KW),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared comparator: held key against the word just read
  sle_cmp u_cmp (
    .key_i   (key_q),
    .entry_i (ram_rdata),
    .res_o   (cmp_res)
  );

  // RAM port control, decoded from the sequencer state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = key_q;
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    unique case (state_q)
      S_IDLE: begin
        // insert into an empty table goes straight to slot zero
        if (s_fire && op_in == sle_pkg::OP_INSERT && is_empty) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = s_axis_tdata_i;
        end
      end
      S_INS_RD, S_DEL_RD, S_SHF_RD: begin
        ram_re = 1'b1;
      end
      S_DMP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = dump_addr;
      end
      S_INS_CMP: begin
        // entry not below the key moves up one slot; otherwise the key lands
        // just above it
        ram_we    = 1'b1;
        ram_waddr = idx_q + AW'(1);
        ram_wdata = cmp_res.gt ? key_q : ram_rdata;
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
      end
      S_SHF_WR: begin
        // close the gap left by the deleted entry
        ram_we    = 1'b1;
        ram_waddr = idx_q - AW'(1);
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, result staging and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      key_q        <= '0;
      idx_q        <= '0;
      count_q      <= '0;
      dump_desc_q  <= 1'b0;
      res_value_q  <= '0;
      res_status_q <= sle_pkg::ST_OK;
      m_tvalid_q   <= 1'b0;
      m_tdata_q    <= '0;
      m_tuser_q    <= sle_pkg::ST_OK;
      m_tlast_q    <= 1'b0;
    end else begin
      // raise the output beat on a load, drop it once taken
      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            key_q <= s_axis_tdata_i;
            idx_q <= '0;
            unique case (op_in)
              sle_pkg::OP_INSERT: begin
                if (is_full) begin
                  res_value_q  <= s_axis_tdata_i;
                  res_status_q <= sle_pkg::ST_FULL;
                  state_q      <= S_EMIT;
                end else if (is_empty) begin
                  count_q      <= CW'(1);
                  res_value_q  <= s_axis_tdata_i;
                  res_status_q <= sle_pkg::ST_OK;
                  state_q      <= S_EMIT;
                end else begin
                  idx_q   <= last_idx;
                  state_q <= S_INS_RD;
                end
              end
              sle_pkg::OP_DELETE: begin
                if (is_empty) begin
                  res_value_q  <= '0;
                  res_status_q <= sle_pkg::ST_NOT_FOUND;
                  state_q      <= S_EMIT;
                end else begin
                  state_q <= S_DEL_RD;
                end
              end
              sle_pkg::OP_DUMP_ASC, sle_pkg::OP_DUMP_DESC: begin
                dump_desc_q <= (op_in == sle_pkg::OP_DUMP_DESC);
                if (is_empty) begin
                  res_value_q  <= '0;
                  res_status_q <= sle_pkg::ST_EMPTY;
                  state_q      <= S_EMIT;
                end else begin
                  state_q <= S_DMP_RD;
                end
              end
            endcase
          end
        end
        S_INS_RD: begin
          state_q <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (cmp_res.gt) begin
            count_q      <= count_q + CW'(1);
            res_value_q  <= key_q;
            res_status_q <= sle_pkg::ST_OK;
            state_q      <= S_EMIT;
          end else if (idx_q == '0) begin
            state_q <= S_INS_PUT;
          end else begin
            idx_q   <= idx_q - AW'(1);
            state_q <= S_INS_RD;
          end
        end
        S_INS_PUT: begin
          count_q      <= count_q + CW'(1);
          res_value_q  <= key_q;
          res_status_q <= sle_pkg::ST_OK;
          state_q      <= S_EMIT;
        end
        S_DEL_RD: begin
          state_q <= S_DEL_CMP;
        end
        S_DEL_CMP: begin
          if (cmp_res.eq) begin
            res_value_q  <= key_q;
            res_status_q <= sle_pkg::ST_OK;
            if (idx_q == last_idx) begin
              count_q <= count_q - CW'(1);
              state_q <= S_EMIT;
            end else begin
              idx_q   <= idx_q + AW'(1);
              state_q <= S_SHF_RD;
            end
          end else if (idx_q == last_idx) begin
            res_value_q  <= '0;
            res_status_q <= sle_pkg::ST_NOT_FOUND;
            state_q      <= S_EMIT;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= S_DEL_RD;
          end
        end
        S_SHF_RD: begin
          state_q <= S_SHF_WR;
        end
        S_SHF_WR: begin
          if (idx_q == last_idx) begin
            count_q <= count_q - CW'(1);
            state_q <= S_EMIT;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= S_SHF_RD;
          end
        end
        S_DMP_RD: begin
          state_q <= S_DMP_OUT;
        end
        S_DMP_OUT: begin
          // hold the read word until the output register frees up
          if (out_free) begin
            m_tdata_q  <= ram_rdata;
            m_tuser_q  <= sle_pkg::ST_OK;
            m_tlast_q  <= (idx_q == last_idx);
            if (idx_q == last_idx) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + AW'(1);
              state_q <= S_DMP_RD;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tdata_q  <= res_value_q;
            m_tuser_q  <= res_status_q;
            m_tlast_q  <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;
  assign m_axis_tlast_o  = m_tlast_q;

`ifndef SYNTHESIS
  // fill level stays within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // an insert into a full table leaves the table size alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && op_in == sle_pkg::OP_INSERT && is_full) |=> (count_q == $past(count_q)))
    else $error("dropped insert changed entry count");

  // the fill level moves by at most one per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)))
    else $error("entry count jumped");

  // the table is written only while an item is in work or being accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == S_IDLE) |-> s_fire)
    else $error("table write while idle");
`endif

endmodule

// ===== hw/rtl/sle_ram.sv =====
// ----------------------------------------------------------------------------
// sle_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sle_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold the last read word until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sle_cmp.sv =====
// ----------------------------------------------------------------------------
// sle_cmp: shared signed key comparator
// Compares the search key with one stored entry per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sle_cmp (
  input  logic signed [sle_pkg::KEY_W-1:0] key_i,
  input  logic signed [sle_pkg::KEY_W-1:0] entry_i,
  output sle_pkg::cmp_res_t                res_o
);

  always_comb begin
    res_o.gt = (key_i > entry_i);
    res_o.eq = (key_i == entry_i);
  end

endmodule

// ===== sim/tb_sorted_list_engine.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_list_engine: self-checking bench for the sorted list engine
// Drives insert, delete and dump beats with random gaps on both streams and
// keeps a shadow sorted table that predicts every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
  logic [15:0]       value;
  sle_pkg::status_e  status;
  logic              last;
} sle_result_t;

// Shadow of the table plus the queue of result beats still owed by the block
class sle_scoreboard;
  localparam int unsigned DEPTH = sle_pkg::CAPACITY_DEF;

  logic signed [15:0] tab [DEPTH];
  int unsigned        fill;
  sle_result_t        owed_q[$];
  int unsigned        errors;

  function new();
    fill   = 0;
    errors = 0;
  endfunction

  function void owe(logic [15:0] value, sle_pkg::status_e status, logic last);
    sle_result_t r;
    r.value  = value;
    r.status = status;
    r.last   = last;
    owed_q.push_back(r);
  endfunction

  function logic [15:0] pick_stored();
    return tab[$urandom_range(fill - 1)];
  endfunction

  // Apply one accepted input beat to the shadow table
  function void note_item(sle_pkg::op_e op, logic signed [15:0] key);
    int unsigned pos;
    int unsigned i;
    case (op)
      sle_pkg::OP_INSERT: begin
        if (fill >= DEPTH) begin
          owe(key, sle_pkg::ST_FULL, 1'b1);
        end else begin
          // a new key goes ahead of stored keys equal to it
          pos = 0;
          while (pos < fill && key > tab[pos]) pos++;
          for (i = fill; i > pos; i--) tab[i] = tab[i - 1];
          tab[pos] = key;
          fill++;
          owe(key, sle_pkg::ST_OK, 1'b1);
        end
      end
      sle_pkg::OP_DELETE: begin
        pos = 0;
        while (pos < fill && tab[pos] != key) pos++;
        if (pos == fill) begin
          owe(16'd0, sle_pkg::ST_NOT_FOUND, 1'b1);
        end else begin
          for (i = pos; i + 1 < fill; i++) tab[i] = tab[i + 1];
          fill--;
          owe(key, sle_pkg::ST_OK, 1'b1);
        end
      end
      default: begin
        if (fill == 0) begin
          owe(16'd0, sle_pkg::ST_EMPTY, 1'b1);
        end else begin
          for (i = 0; i < fill; i++) begin
            owe((op == sle_pkg::OP_DUMP_ASC) ? tab[i] : tab[fill - 1 - i],
                sle_pkg::ST_OK, i + 1 == fill);
          end
        end
      end
    endcase
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 50) $display("[tb] mismatch: %s", msg);
  endtask

  task check_result(logic [15:0] value, logic [1:0] status, logic last);
    sle_result_t e;
    if (owed_q.size() == 0) begin
      report($sformatf("unexpected beat value %0d status %0d last %0b",
                       $signed(value), status, last));
      return;
    end
    e = owed_q.pop_front();
    if (value !== e.value)
      report($sformatf("value %0d, want %0d", $signed(value), $signed(e.value)));
    if (status !== e.status)
      report($sformatf("status %0d, want %0d", status, e.status));
    if (last !== e.last)
      report($sformatf("last %0b, want %0b", last, e.last));
  endtask
endclass

module tb_sorted_list_engine;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned TAIL_CYCLES  = 100;

  logic        clk      = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = 16'd0;
  logic [1:0]  s_tuser  = 2'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  sle_scoreboard keeper;

  bit          hold_req  = 1'b0;
  int unsigned hold_cnt  = 0;
  int unsigned rx_run    = 0;
  int unsigned rx_wait   = 0;
  int unsigned cycle_cnt = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_list_engine u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(4, 1);
    return $urandom_range(40, 10);
  endfunction

  // Receiver: random stalls, ready-only stretches, and one long hold on request
  always @(negedge clk) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_req || hold_cnt != 0) begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      hold_cnt--;
      m_tready <= 1'b0;
    end else if (rx_run != 0) begin
      rx_run--;
      m_tready <= 1'b1;
    end else if (rx_wait != 0) begin
      rx_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      rx_run  = ($urandom_range(99) < 12) ? $urandom_range(80, 20) : $urandom_range(2, 0);
      rx_wait = gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst_ni && m_tvalid && m_tready) keeper.check_result(m_tdata, m_tuser, m_tlast);
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("[sorted_list_engine] ERROR");
      $finish;
    end
  end

  // Offer one beat and hold it until the block takes it
  task automatic send_item(input sle_pkg::op_e op, input logic [15:0] key);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= key;
    do @(posedge clk); while (!s_tready);
    keeper.note_item(op, key);
  endtask

  task automatic idle_in(input int unsigned n);
    if (n != 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= 16'($urandom);
      s_tuser  <= 2'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic apply(input sle_pkg::op_e op, input logic [15:0] key);
    send_item(op, key);
    idle_in(gap_len());
  endtask

  // Stop offering and wait for every owed result
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (keeper.owed_q.size() != 0) @(posedge clk);
  endtask

  function automatic sle_pkg::op_e pick_op(input int unsigned mode);
    int unsigned r;
    int unsigned ins_t;
    int unsigned del_t;
    case (mode)
      0:       begin ins_t = 80; del_t = 90; end  // fill up
      1:       begin ins_t = 10; del_t = 85; end  // drain down
      2:       begin ins_t = 40; del_t = 80; end
      default: begin ins_t = 30; del_t = 60; end  // dump heavy
    endcase
    r = $urandom_range(99);
    if (r < ins_t) return sle_pkg::OP_INSERT;
    if (r < del_t) return sle_pkg::OP_DELETE;
    return $urandom_range(1) ? sle_pkg::OP_DUMP_ASC : sle_pkg::OP_DUMP_DESC;
  endfunction

  function automatic logic [15:0] pick_key(input sle_pkg::op_e op);
    int unsigned r;
    logic [15:0] k;
    r = $urandom_range(99);
    if (op == sle_pkg::OP_DELETE && keeper.fill != 0 && r < 75) return keeper.pick_stored();
    if (op == sle_pkg::OP_INSERT && keeper.fill != 0 && r < 10) return keeper.pick_stored();
    r = $urandom_range(99);
    if (r < 45) begin
      // narrow pool so duplicates are common
      k = 16'($urandom_range(8));
      return k - 16'd4;
    end
    if (r < 55) begin
      case ($urandom_range(3))
        0:       return 16'h8000;
        1:       return 16'h7fff;
        2:       return 16'h0000;
        default: return 16'hffff;
      endcase
    end
    return 16'($urandom);
  endfunction

  initial begin : stimulus
    int unsigned  sent;
    int unsigned  ep_idx;
    int unsigned  ep_len;
    int unsigned  mode;
    int unsigned  burst_left;
    bit           no_gap;
    sle_pkg::op_e op;
    logic [15:0]  key;

    keeper = new();
    repeat (3) @(negedge clk);
    rst_ni <= 1'b1;

    // Directed: empty table, extremes, duplicates, misses, full clean-out
    apply(sle_pkg::OP_DUMP_ASC,  16'h1234);
    apply(sle_pkg::OP_DUMP_DESC, 16'h0000);
    apply(sle_pkg::OP_DELETE,    16'd5);
    apply(sle_pkg::OP_INSERT,    16'h0000);
    apply(sle_pkg::OP_INSERT,    16'h8000);
    apply(sle_pkg::OP_INSERT,    16'h7fff);
    apply(sle_pkg::OP_INSERT,    16'hffff);
    apply(sle_pkg::OP_INSERT,    16'h0000);
    apply(sle_pkg::OP_INSERT,    16'h0001);
    apply(sle_pkg::OP_DUMP_ASC,  16'hffff);
    apply(sle_pkg::OP_DUMP_DESC, 16'h5a5a);
    apply(sle_pkg::OP_DELETE,    16'h0000);
    apply(sle_pkg::OP_DELETE,    16'd1234);
    apply(sle_pkg::OP_DELETE,    16'h8000);
    apply(sle_pkg::OP_DELETE,    16'h7fff);
    apply(sle_pkg::OP_INSERT,    16'h5555);
    apply(sle_pkg::OP_INSERT,    16'haaaa);
    apply(sle_pkg::OP_DUMP_ASC,  16'haaaa);
    apply(sle_pkg::OP_DELETE,    16'hffff);
    apply(sle_pkg::OP_DELETE,    16'h0000);
    apply(sle_pkg::OP_DELETE,    16'h0001);
    apply(sle_pkg::OP_DELETE,    16'h5555);
    apply(sle_pkg::OP_DELETE,    16'haaaa);
    apply(sle_pkg::OP_DUMP_DESC, 16'hffff);

    // Random episodes; the first favours inserts, the second favours deletes
    sent       = 0;
    ep_idx     = 0;
    burst_left = 0;
    while (sent < RANDOM_ITEMS) begin
      ep_len = $urandom_range(60, 20);
      mode   = (ep_idx < 2) ? ep_idx : $urandom_range(3);
      no_gap = ($urandom_range(3) == 0);
      repeat (ep_len) begin
        if (sent == 100) begin
          // long receiver hold while beats keep coming
          hold_req   = 1'b1;
          burst_left = 40;
        end
        if (sent == 250) drain();
        op  = pick_op(mode);
        key = pick_key(op);
        send_item(op, key);
        sent++;
        if (burst_left != 0) burst_left--;
        else if (!no_gap) idle_in(gap_len());
      end
      ep_idx++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (keeper.errors == 0 && keeper.owed_q.size() == 0) begin
      $display("[sorted_list_engine] OK");
    end else begin
      $display("[sorted_list_engine] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sle_pkg.sv
hw/rtl/sle_ram.sv
hw/rtl/sle_cmp.sv
hw/rtl/sorted_list_engine.sv
sim/tb_sorted_list_engine.sv
